@@ hdl/svcb_pkg.sv @@
// Package for the SVCB RDATA validator: phase, error and key codes, the
// result record type and the per-key length check. No dependencies.
package svcb_pkg;

   localparam logic [7:0] MaxParamsReset = 8'd16;
   localparam int unsigned QueueDepth = 4;

   typedef enum logic [8:0] {
      PH_PRIO_HI  = 9'b000000001,
      PH_PRIO_LO  = 9'b000000010,
      PH_NAME_LEN = 9'b000000100,
      PH_LABEL    = 9'b000001000,
      PH_KEY_HI   = 9'b000010000,
      PH_KEY_LO   = 9'b000100000,
      PH_LEN_HI   = 9'b001000000,
      PH_LEN_LO   = 9'b010000000,
      PH_VALUE    = 9'b100000000
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_TRUNCATED = 3'd1,
      ERR_BAD_NAME  = 3'd2,
      ERR_KEY_ORDER = 3'd3,
      ERR_TOO_MANY  = 3'd4,
      ERR_BAD_VALUE = 3'd5
   } err_type;

   localparam logic [15:0] KeyMandatory = 16'd0;
   localparam logic [15:0] KeyAlpn      = 16'd1;
   localparam logic [15:0] KeyNoDefAlpn = 16'd2;
   localparam logic [15:0] KeyPort      = 16'd3;
   localparam logic [15:0] KeyIpv4Hint  = 16'd4;
   localparam logic [15:0] KeyIpv6Hint  = 16'd6;

   typedef struct packed {
      logic        kind;
      logic        ok;
      err_type     err;
      logic [15:0] prio;
      logic [15:0] key;
      logic [15:0] offset;
      logic [15:0] length;
      logic [7:0]  count;
      logic [7:0]  tlen;
      logic        last;
   } result_type;

   function automatic logic length_ok(input logic [15:0] key, input logic [15:0] len);
      logic r;
      begin
         case (key)
            KeyMandatory: r = (len != 16'd0) && (len[0] == 1'b0);
            KeyAlpn:      r = (len != 16'd0);
            KeyNoDefAlpn: r = (len == 16'd0);
            KeyPort:      r = (len == 16'd2);
            KeyIpv4Hint:  r = (len != 16'd0) && (len[1:0] == 2'd0);
            KeyIpv6Hint:  r = (len != 16'd0) && (len[3:0] == 4'd0);
            default:      r = 1'b1;
         endcase
         return r;
      end
   endfunction

endpackage

@@ hdl/svcb_rdata_validator_core.sv @@
// Top level of the SVCB RDATA validator: byte parser, checks and result queue.
// Depends on svcb_pkg.
//
//  channel | ports                                   | direction
//  req     | req_valid/ready, data_byte, last_byte    | in
//  rsp     | rsp_valid/ready, result fields           | out
//  csr     | csr_valid/ready, csr_wdata (max params)  | in
//
// One byte is parsed in the cycle it is accepted; its reports and verdict
// (at most two items) enter a four-entry result queue. req_ready is high
// while the queue has room for two items, so bytes flow and items leave one
// a cycle while the result side keeps up. Reset is synchronous and returns
// the parser to the priority field and max_parameters to 16.
module svcb_rdata_validator_core
   import svcb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic        rsp_record_ok,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_priority_res,
   output logic [15:0] rsp_param_key,
   output logic [15:0] rsp_value_offset,
   output logic [15:0] rsp_value_length,
   output logic [7:0]  rsp_param_count,
   output logic [7:0]  rsp_target_length,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned PtrW = $clog2(QueueDepth);

   logic [7:0]  max_params_ff;
   phase_type   phase_ff, phase_in;
   logic [15:0] prio_ff, prio_in, pos_ff, pos_in;
   logic [8:0]  name_len_ff, name_len_in;
   logic [5:0]  label_rem_ff, label_rem_in;
   logic [15:0] prev_key_ff, prev_key_in, cur_key_ff, cur_key_in;
   logic        first_key_ff, first_key_in;
   logic [15:0] cur_len_ff, cur_len_in, val_rem_ff, val_rem_in;
   logic [7:0]  count_ff, count_in;
   err_type     err_ff, err_in;
   logic [7:0]  alpn_rem_ff, alpn_rem_in;
   logic [15:0] mand_prev_ff, mand_prev_in;
   logic        mand_first_ff, mand_first_in;
   logic        vphase_ff, vphase_in;
   logic [7:0]  mand_hi_ff, mand_hi_in;

   logic        report, accept;
   result_type  rep_item, ver_item;

   result_type       queue_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]    fill_ff;

   assign accept    = req_valid && req_ready;
   assign req_ready = (fill_ff <= (PtrW+1)'(QueueDepth - 2));
   assign csr_ready = 1'b1;

   always_comb begin
      logic [15:0] mkey;
      logic [15:0] klo;
      logic [15:0] llo;
      logic [15:0] vrem_m1;
      err_type     fin_err;
      phase_in      = phase_ff;
      prio_in       = prio_ff;
      name_len_in   = name_len_ff;
      label_rem_in  = label_rem_ff;
      prev_key_in   = prev_key_ff;
      first_key_in  = first_key_ff;
      cur_key_in    = cur_key_ff;
      cur_len_in    = cur_len_ff;
      val_rem_in    = val_rem_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      alpn_rem_in   = alpn_rem_ff;
      mand_prev_in  = mand_prev_ff;
      mand_first_in = mand_first_ff;
      vphase_in     = vphase_ff;
      mand_hi_in    = mand_hi_ff;
      report        = 1'b0;
      pos_in        = pos_ff + 16'd1;
      mkey          = {mand_hi_ff, req_data_byte};
      klo           = {cur_key_ff[15:8], req_data_byte};
      llo           = {cur_len_ff[15:8], req_data_byte};
      vrem_m1       = val_rem_ff - 16'd1;

      if (err_ff == ERR_NONE) begin
         case (phase_ff)
            PH_PRIO_HI: begin
               prio_in  = {req_data_byte, 8'd0};
               phase_in = PH_PRIO_LO;
            end
            PH_PRIO_LO: begin
               prio_in  = {prio_ff[15:8], req_data_byte};
               phase_in = PH_NAME_LEN;
            end
            PH_NAME_LEN: begin
               name_len_in = name_len_ff + 9'd1;
               if (req_data_byte > 8'd63 || name_len_in > 9'd255) begin
                  err_in = ERR_BAD_NAME;
               end else if (req_data_byte == 8'd0) begin
                  phase_in = PH_KEY_HI;
               end else begin
                  label_rem_in = req_data_byte[5:0];
                  phase_in     = PH_LABEL;
               end
            end
            PH_LABEL: begin
               name_len_in = name_len_ff + 9'd1;
               if (name_len_in > 9'd255) begin
                  err_in = ERR_BAD_NAME;
               end else begin
                  label_rem_in = label_rem_ff - 6'd1;
                  if (label_rem_in == 6'd0) phase_in = PH_NAME_LEN;
               end
            end
            PH_KEY_HI: begin
               if (count_ff >= max_params_ff) begin
                  err_in = ERR_TOO_MANY;
               end else begin
                  cur_key_in = {req_data_byte, 8'd0};
                  phase_in   = PH_KEY_LO;
               end
            end
            PH_KEY_LO: begin
               cur_key_in = klo;
               if (!first_key_ff && klo <= prev_key_ff) err_in = ERR_KEY_ORDER;
               else phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               cur_len_in = {req_data_byte, 8'd0};
               phase_in   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               cur_len_in = llo;
               if (!length_ok(cur_key_ff, llo)) begin
                  err_in = ERR_BAD_VALUE;
               end else if (llo == 16'd0) begin
                  report = 1'b1;
               end else begin
                  val_rem_in    = llo;
                  alpn_rem_in   = 8'd0;
                  mand_first_in = 1'b1;
                  mand_prev_in  = 16'd0;
                  vphase_in     = 1'b0;
                  phase_in      = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (cur_key_ff == KeyMandatory) begin
                  if (!vphase_ff) begin
                     mand_hi_in = req_data_byte;
                     vphase_in  = 1'b1;
                  end else begin
                     vphase_in = 1'b0;
                     if (mkey == 16'd0 || (!mand_first_ff && mkey <= mand_prev_ff))
                        err_in = ERR_BAD_VALUE;
                     mand_first_in = 1'b0;
                     mand_prev_in  = mkey;
                  end
               end else if (cur_key_ff == KeyAlpn) begin
                  if (alpn_rem_ff == 8'd0) begin
                     if (req_data_byte == 8'd0 || {8'd0, req_data_byte} > vrem_m1)
                        err_in = ERR_BAD_VALUE;
                     alpn_rem_in = req_data_byte;
                  end else begin
                     alpn_rem_in = alpn_rem_ff - 8'd1;
                  end
               end
               val_rem_in = vrem_m1;
               if (err_in == ERR_NONE && vrem_m1 == 16'd0) begin
                  if (cur_key_ff == KeyAlpn && alpn_rem_in != 8'd0) err_in = ERR_BAD_VALUE;
                  else report = 1'b1;
               end
            end
            default: err_in = ERR_TRUNCATED;
         endcase
      end

      if (report) begin
         count_in     = count_ff + 8'd1;
         prev_key_in  = cur_key_in;
         first_key_in = 1'b0;
         phase_in     = PH_KEY_HI;
      end

      rep_item.kind   = 1'b0;
      rep_item.ok     = 1'b0;
      rep_item.err    = ERR_NONE;
      rep_item.prio   = prio_in;
      rep_item.key    = cur_key_in;
      rep_item.offset = pos_ff + 16'd1 - cur_len_in;
      rep_item.length = cur_len_in;
      rep_item.count  = count_in;
      rep_item.tlen   = name_len_in[7:0];
      rep_item.last   = !req_last_byte;

      fin_err = err_in;
      if (fin_err == ERR_NONE && phase_in != PH_KEY_HI) fin_err = ERR_TRUNCATED;
      ver_item.kind   = 1'b1;
      ver_item.ok     = (fin_err == ERR_NONE);
      ver_item.err    = fin_err;
      ver_item.prio   = prio_in;
      ver_item.key    = 16'd0;
      ver_item.offset = 16'd0;
      ver_item.length = 16'd0;
      ver_item.count  = count_in;
      ver_item.tlen   = name_len_in[7:0];
      ver_item.last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_params_ff <= MaxParamsReset;
      end else if (csr_valid && csr_ready) begin
         max_params_ff <= csr_wdata;
      end
   end

   // Parser state; a last byte sends everything back to the start of a record.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         phase_ff      <= PH_PRIO_HI;
         prio_ff       <= 16'd0;
         pos_ff        <= 16'd0;
         name_len_ff   <= 9'd0;
         label_rem_ff  <= 6'd0;
         prev_key_ff   <= 16'd0;
         first_key_ff  <= 1'b1;
         cur_key_ff    <= 16'd0;
         cur_len_ff    <= 16'd0;
         val_rem_ff    <= 16'd0;
         count_ff      <= 8'd0;
         err_ff        <= ERR_NONE;
         alpn_rem_ff   <= 8'd0;
         mand_prev_ff  <= 16'd0;
         mand_first_ff <= 1'b1;
         vphase_ff     <= 1'b0;
         mand_hi_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         prio_ff       <= prio_in;
         pos_ff        <= pos_in;
         name_len_ff   <= name_len_in;
         label_rem_ff  <= label_rem_in;
         prev_key_ff   <= prev_key_in;
         first_key_ff  <= first_key_in;
         cur_key_ff    <= cur_key_in;
         cur_len_ff    <= cur_len_in;
         val_rem_ff    <= val_rem_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         alpn_rem_ff   <= alpn_rem_in;
         mand_prev_ff  <= mand_prev_in;
         mand_first_ff <= mand_first_in;
         vphase_ff     <= vphase_in;
         mand_hi_ff    <= mand_hi_in;
      end
   end

   logic           push_a, push_b, pop;
   logic [PtrW:0]  n_push;
   result_type     item_a, item_b;

   assign push_a = accept && (report || req_last_byte);
   assign push_b = accept && report && req_last_byte;
   assign item_a = report ? rep_item : ver_item;
   assign item_b = ver_item;
   assign n_push = (PtrW+1)'(push_a) + (PtrW+1)'(push_b);
   assign pop    = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push_a) queue_ff[wr_ptr_ff] <= item_a;
      if (push_b) queue_ff[wr_ptr_ff + PtrW'(1)] <= item_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + n_push[PtrW-1:0];
         if (pop) rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         fill_ff <= fill_ff + n_push - (PtrW+1)'(pop);
      end
   end

   result_type head;
   assign head = queue_ff[rd_ptr_ff];

   assign rsp_valid         = (fill_ff != '0);
   assign rsp_result_kind   = head.kind;
   assign rsp_record_ok     = head.ok;
   assign rsp_error_code    = head.err;
   assign rsp_priority_res  = head.prio;
   assign rsp_param_key     = head.key;
   assign rsp_value_offset  = head.offset;
   assign rsp_value_length  = head.length;
   assign rsp_param_count   = head.count;
   assign rsp_target_length = head.tlen;
   assign rsp_last_result   = head.last;

endmodule
